@@ src/first_free_page_allocator_top_macros.svh @@
// Assertion macros for the first-free page allocator.
`ifndef FIRST_FREE_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FREE_PAGE_ALLOCATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FFPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FFPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FFPA_ASSERT_NOW(label, ante, cons, msg)
`define FFPA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ src/ffpa_pkg.sv @@
// Package with the types, sizes and codes shared by the page allocator files.
`timescale 1ns / 1ps
`default_nettype none

package ffpa_pkg;

    // Managed region: number of pages and log2 of the page size in bytes.
    localparam int PAGE_COUNT = 1024;
    localparam int PAGE_BITS  = 12;

    // Field and bus widths.
    localparam int ADDR_W   = 40;
    localparam int DATA_W   = 64;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int PADDR_W  = 4;

    // The used-flag bitmap is held as rows of 32 flags.
    localparam int WORD_W = 32;
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int ROWS   = (PAGE_COUNT + WORD_W - 1) / WORD_W;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W = ROW_W + BIT_W;
    localparam int CNT_W  = SLOT_W + 1;
    localparam int PG_W   = ADDR_W - PAGE_BITS;

    // Request codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC_PHYS = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC_KERN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE       = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Register select, taken from the top address bit.
    localparam logic REG_REGION_BASE   = 1'b0;
    localparam logic REG_KERNEL_OFFSET = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FREE_SUB,
        S_FREE_CHK,
        S_FREE_WR,
        S_SCAN,
        S_ADD_BASE,
        S_ADD_KOFF,
        S_RESULT
    } t_state;

    // Outcome of the search for a free flag within one bitmap row.
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } t_find;

endpackage

`default_nettype wire

@@ src/ffpa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ffpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/ffpa_find.sv @@
// Lowest-free-flag search over one row of the used-flag bitmap.
`timescale 1ns / 1ps
`default_nettype none

module ffpa_find (
    input  wire logic [ffpa_pkg::WORD_W-1:0] i_word,
    input  wire logic [ffpa_pkg::ROW_W-1:0]  i_row,
    output ffpa_pkg::t_find                  o_find
);

    import ffpa_pkg::*;

    logic [WORD_W-1:0] w_free;

    // A flag counts as free only if it is clear and names a page inside the region.
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            w_free[b] = !i_word[b] &&
                        ({1'b0, i_row, BIT_W'(b)} < CNT_W'(PAGE_COUNT));
        end
    end

    // Priority encoder: the lowest free position wins.
    always_comb begin
        o_find = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (w_free[b]) begin
                o_find.found = 1'b1;
                o_find.pos   = BIT_W'(b);
            end
        end
    end

endmodule

`default_nettype wire

@@ src/first_free_page_allocator_top.sv @@
// First-free page allocator: bitmap of used flags, request sequencer and register port.
//
// Requests arrive on i_cmd_valid / o_cmd_ready with i_command and i_free_address;
// one response per request leaves on o_rsp_valid / i_rsp_ready with o_page_address
// and o_status. Both channels complete a transfer when valid and ready are high.
// The block works on one request at a time and holds o_cmd_ready low meanwhile.
// An allocate scans the bitmap one 32-flag row per cycle through a single read
// port (ROWS = 32 rows by default), then adds the region base; a kernel allocate
// then adds its offset with the same shared 64-bit adder that forms the physical
// address. A free steps through subtract, check and read, write back, respond.
// A rejected free skips the read and write back, and an unknown code goes
// straight to respond. o_cmd_ready rises the cycle after the load.
// After reset the bitmap is cleared one row per cycle, all ROWS rows, with
// o_cmd_ready low; register writes are taken during that time as usual.
// The response sits in an output register; a stalled receiver holds the finished
// response in the sequencer until the register is free, while o_cmd_ready stays low.
// Registers sit on an APB-style port: region base at address 0, kernel offset at 8.
`timescale 1ns / 1ps
`default_nettype none

`include "first_free_page_allocator_top_macros.svh"

module first_free_page_allocator_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Request channel
    input  wire logic                              i_cmd_valid,
    output logic                                   o_cmd_ready,
    input  wire logic [ffpa_pkg::CMD_W-1:0]        i_command,
    input  wire logic [ffpa_pkg::ADDR_W-1:0]       i_free_address,
    // Response channel
    output logic                                   o_rsp_valid,
    input  wire logic                              i_rsp_ready,
    output logic      [ffpa_pkg::DATA_W-1:0]       o_page_address,
    output logic      [ffpa_pkg::STATUS_W-1:0]     o_status,
    // Register port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ffpa_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [ffpa_pkg::DATA_W-1:0]       pwdata,
    output logic      [ffpa_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready
);

    import ffpa_pkg::*;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    // Configuration registers.
    logic [ADDR_W-1:0]   r_region_base;
    logic [DATA_W-1:0]   r_kernel_offset;

    // Sequencer registers and their next values.
    t_state              r_state,     n_state;
    logic [ROW_W-1:0]    r_row,       n_row;
    logic [CMD_W-1:0]    r_cmd,       n_cmd;
    logic [ADDR_W-1:0]   r_free_addr, n_free_addr;
    logic [SLOT_W-1:0]   r_slot,      n_slot;
    logic [DATA_W-1:0]   r_sum,       n_sum;
    logic                r_carry,     n_carry;
    logic [STATUS_W-1:0] r_status,    n_status;

    // Output register.
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_addr;
    logic [STATUS_W-1:0] r_out_status;

    // Shared adder.
    logic [DATA_W-1:0]   w_add_a;
    logic [DATA_W-1:0]   w_add_b;
    logic                w_add_cin;
    logic [DATA_W:0]     w_add_sum;

    // Bitmap memory ports.
    logic                w_wr_en;
    logic [ROW_W-1:0]    w_wr_addr;
    logic [WORD_W-1:0]   w_wr_data;
    logic                w_rd_en;
    logic [ROW_W-1:0]    w_rd_addr;
    logic [WORD_W-1:0]   w_rd_data;

    // Free address decode and row search.
    logic [ADDR_W-1:0]   w_off;
    logic [SLOT_W-1:0]   w_pg;
    logic                w_free_ok;
    t_find               w_find;
    logic                w_load;
    logic                w_cfg_wr;

    // Register port: completion without wait states, writes on the access phase.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[PADDR_W-1] == REG_KERNEL_OFFSET) ? r_kernel_offset
                                                              : DATA_W'(r_region_base);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base   <= '0;
            r_kernel_offset <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[PADDR_W-1])
                REG_REGION_BASE: begin
                    r_region_base <= pwdata[ADDR_W-1:0];
                end
                REG_KERNEL_OFFSET: begin
                    r_kernel_offset <= pwdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Used-flag bitmap, one row of flags per word.
    ffpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Lowest free flag in the row just read.
    ffpa_find u_find (
        .i_word (w_rd_data),
        .i_row  (r_row),
        .o_find (w_find)
    );

    // The one 64-bit adder, shared by the range check and both address sums.
    assign w_add_sum = {1'b0, w_add_a} + {1'b0, w_add_b} + {{DATA_W{1'b0}}, w_add_cin};

    // Free address checks on the registered offset from the base.
    assign w_off     = r_sum[ADDR_W-1:0];
    assign w_pg      = w_off[PAGE_BITS +: SLOT_W];
    assign w_free_ok = r_carry &&
                       (w_off[PAGE_BITS-1:0] == '0) &&
                       (w_off[ADDR_W-1:PAGE_BITS] < PG_W'(PAGE_COUNT));

    // The finished response moves to the output register once it is free.
    assign w_load = (r_state == S_RESULT) && (!r_out_valid || i_rsp_ready);

    assign o_cmd_ready = (r_state == S_IDLE);

    // Sequencer: next state, adder operands and memory access.
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_cmd       = r_cmd;
        n_free_addr = r_free_addr;
        n_slot      = r_slot;
        n_sum       = r_sum;
        n_carry     = r_carry;
        n_status    = r_status;
        w_add_a     = '0;
        w_add_b     = '0;
        w_add_cin   = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_addr   = '0;
        w_wr_data   = '0;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;

        case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_row;
                if (r_row == ROW_LAST) begin
                    n_row   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end

            S_IDLE: begin
                // Row 0 is read ahead so that a scan can start at once.
                w_rd_en   = 1'b1;
                w_rd_addr = '0;
                if (i_cmd_valid) begin
                    n_cmd       = i_command;
                    n_free_addr = i_free_address;
                    n_row       = '0;
                    case (i_command)
                        CMD_ALLOC_PHYS, CMD_ALLOC_KERN: begin
                            n_state = S_SCAN;
                        end
                        CMD_FREE: begin
                            n_state = S_FREE_SUB;
                        end
                        default: begin
                            n_sum    = '0;
                            n_status = ST_OK;
                            n_state  = S_RESULT;
                        end
                    endcase
                end
            end

            S_FREE_SUB: begin
                // Offset from the base; the carry out is set when the address is not below it.
                w_add_a   = DATA_W'(r_free_addr);
                w_add_b   = ~DATA_W'(r_region_base);
                w_add_cin = 1'b1;
                n_sum     = w_add_sum[DATA_W-1:0];
                n_carry   = w_add_sum[DATA_W];
                n_state   = S_FREE_CHK;
            end

            S_FREE_CHK: begin
                if (w_free_ok) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_pg[SLOT_W-1:BIT_W];
                    n_slot    = w_pg;
                    n_state   = S_FREE_WR;
                end else begin
                    n_sum    = '0;
                    n_status = ST_RANGE;
                    n_state  = S_RESULT;
                end
            end

            S_FREE_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_slot[SLOT_W-1:BIT_W];
                w_wr_data = w_rd_data & ~(WORD_W'(1) << r_slot[BIT_W-1:0]);
                n_sum     = '0;
                n_status  = ST_OK;
                n_state   = S_RESULT;
            end

            S_SCAN: begin
                if (w_find.found) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_row;
                    w_wr_data = w_rd_data | (WORD_W'(1) << w_find.pos);
                    n_slot    = {r_row, w_find.pos};
                    n_state   = S_ADD_BASE;
                end else if (r_row == ROW_LAST) begin
                    n_sum    = '0;
                    n_status = ST_FULL;
                    n_state  = S_RESULT;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_row + 1'b1;
                    n_row     = r_row + 1'b1;
                end
            end

            S_ADD_BASE: begin
                w_add_a  = DATA_W'(r_region_base);
                w_add_b  = DATA_W'(r_slot) << PAGE_BITS;
                n_sum    = w_add_sum[DATA_W-1:0];
                n_status = ST_OK;
                n_state  = (r_cmd == CMD_ALLOC_KERN) ? S_ADD_KOFF : S_RESULT;
            end

            S_ADD_KOFF: begin
                w_add_a = r_sum;
                w_add_b = r_kernel_offset;
                n_sum   = w_add_sum[DATA_W-1:0];
                n_state = S_RESULT;
            end

            S_RESULT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer state; reset starts the clearing pass over the bitmap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    // Request payload and working values.
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_free_addr <= n_free_addr;
        r_slot      <= n_slot;
        r_sum       <= n_sum;
        r_carry     <= n_carry;
        r_status    <= n_status;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_addr   <= r_sum;
            r_out_status <= r_status;
        end
    end

    assign o_rsp_valid    = r_out_valid;
    assign o_page_address = r_out_addr;
    assign o_status       = r_out_status;

    // An accepted request always takes the sequencer out of idle.
    `FFPA_ASSERT_NEXT(a_accept_busy, i_cmd_valid && o_cmd_ready, r_state != S_IDLE, "request accepted but sequencer stayed idle")

    // A full region never reports an address.
    `FFPA_ASSERT_NOW(a_full_zero, o_rsp_valid && (o_status == ST_FULL), o_page_address == '0, "full status with a non-zero address")

    // The response status is always one of the defined codes.
    `FFPA_ASSERT_NOW(a_status_code, o_rsp_valid, (o_status == ST_OK) || (o_status == ST_FULL) || (o_status == ST_RANGE), "undefined response status")

    // Scanning and clearing never run past the last bitmap row.
    `FFPA_ASSERT_NOW(a_row_bound, (r_state == S_SCAN) || (r_state == S_CLEAR), r_row <= ROW_LAST, "bitmap row beyond the last row")

endmodule

`default_nettype wire
